FILE: hdl/fust_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the first-unique-symbol tracker
// no dependencies; imported by fust_count_mem and first_unique_symbol_tracker
package fust_pkg;

   localparam int SYMBOL_BITS_DEF = 8;   // default symbol alphabet width
   localparam int DATA_BITS       = 8;   // width of the symbol fields on the ports
   localparam int CNT_BITS        = 2;   // occurrence count width

   localparam logic [CNT_BITS-1:0]  CNT_ZERO  = 2'd0;
   localparam logic [CNT_BITS-1:0]  CNT_ONE   = 2'd1;
   localparam logic [CNT_BITS-1:0]  CNT_SAT   = 2'd2;
   localparam logic [DATA_BITS-1:0] NONE_MARK = 8'd35;   // '#'

   // request to the occurrence count memory
   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [CNT_BITS-1:0] wr_data;
   } cnt_cmd_type;

endpackage

FILE: hdl/fust_count_mem.sv
`timescale 1ns / 1ps
// occurrence count memory: one write port, one registered read port
// clears itself after reset with a one-entry-per-cycle sweep; uses fust_pkg
module fust_count_mem #(
   parameter int SYMBOL_BITS = fust_pkg::SYMBOL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fust_pkg::cnt_cmd_type         cnt_cmd,
   input  logic [SYMBOL_BITS-1:0]        rd_addr,
   input  logic [SYMBOL_BITS-1:0]        wr_addr,
   output logic [fust_pkg::CNT_BITS-1:0] rd_data,
   output logic                          ready
);
   import fust_pkg::*;

   localparam int DEPTH = 1 << SYMBOL_BITS;

   logic [CNT_BITS-1:0]    cnt_mem [DEPTH];
   logic [CNT_BITS-1:0]    rd_data_ff;
   logic                   clearing_ff;
   logic                   clearing_in;
   logic [SYMBOL_BITS-1:0] clr_idx_ff;
   logic [SYMBOL_BITS-1:0] clr_idx_in;
   logic                   mem_wr_en;
   logic [SYMBOL_BITS-1:0] mem_wr_addr;
   logic [CNT_BITS-1:0]    mem_wr_data;

   // clearing sweep
   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == {SYMBOL_BITS{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // sweep owns the write port while it runs
   assign mem_wr_en   = clearing_ff | cnt_cmd.wr_en;
   assign mem_wr_addr = clearing_ff ? clr_idx_ff : wr_addr;
   assign mem_wr_data = clearing_ff ? CNT_ZERO : cnt_cmd.wr_data;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         cnt_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_cmd.rd_en) begin
         rd_data_ff <= cnt_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = ~clearing_ff;

   // no user write may collide with the clearing sweep
   a_no_wr_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !cnt_cmd.wr_en)
      else $error("count write during clearing sweep");

   // the sweep stops in the cycle after it clears the last entry
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (clearing_ff && clr_idx_ff == {SYMBOL_BITS{1'b1}}) |=> !clearing_ff)
      else $error("clearing sweep did not stop at the last entry");

   // once cleared, the memory never starts clearing again without reset
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clearing_ff |=> !clearing_ff)
      else $error("clearing sweep restarted");

endmodule

FILE: hdl/first_unique_symbol_tracker.sv
`timescale 1ns / 1ps
// top level of the first-unique-symbol tracker: control sequencer,
// arrival-order queue memory and output register; uses fust_pkg, fust_count_mem
//
// usage
//   req channel: one 8-bit symbol per item on req_tdata; symbols are masked to
//   SYMBOL_BITS bits. rsp channel: one item per request item; rsp_tdata holds
//   the earliest symbol seen exactly once so far, rsp_tuser is the found flag.
//   with no such symbol found is 0 and the data is '#' (35).
//   result path: after acceptance the count update runs in S_UPD; every stale
//   head popped while entries remain behind it then adds a queue memory read
//   (S_QRD) and a count memory read of the new head (S_CCHK), while a pop that
//   empties the queue adds nothing; the result then waits for a free output register.
//   items: no new item is taken until the sequencer is back in S_IDLE, after the
//   count read-modify-write, any pops and the output handoff; each symbol is
//   popped at most once over the whole stream, so at most 2^SYMBOL_BITS pops.
//   reset: synchronous, active high. afterwards the count memory is cleared
//   by a sweep over all 2^SYMBOL_BITS entries (256 by default); req_tready stays low
//   until it finishes.
//   stalls: the output register parts the channels; an item may be accepted
//   while a result waits, and its own result waits in the sequencer until
//   the output register is free.
module first_unique_symbol_tracker #(
   parameter int SYMBOL_BITS = fust_pkg::SYMBOL_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fust_pkg::DATA_BITS-1:0] req_tdata,   // [7:0] symbol
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fust_pkg::DATA_BITS-1:0] rsp_tdata,   // [7:0] first_once
   output logic                           rsp_tuser    // [0] found
);
   import fust_pkg::*;

   localparam int DEPTH    = 1 << SYMBOL_BITS;
   localparam int PTR_BITS = SYMBOL_BITS + 1;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;   // waiting for an item
   localparam logic [2:0] S_UPD  = 3'd1;   // count read-modify-write, push or pop
   localparam logic [2:0] S_QRD  = 3'd2;   // new head symbol read from queue
   localparam logic [2:0] S_CCHK = 3'd3;   // count of new head symbol checked
   localparam logic [2:0] S_OUT  = 3'd4;   // result waits for output register

   logic [2:0]             state_ff;
   logic [2:0]             state_in;
   logic [SYMBOL_BITS-1:0] sym_ff;
   logic [SYMBOL_BITS-1:0] sym_in;
   logic [PTR_BITS-1:0]    head_ff;
   logic [PTR_BITS-1:0]    head_in;
   logic [PTR_BITS-1:0]    tail_ff;
   logic [PTR_BITS-1:0]    tail_in;
   logic [SYMBOL_BITS-1:0] hsym_ff;       // cached copy of queue[head]
   logic [SYMBOL_BITS-1:0] hsym_in;
   logic [PTR_BITS-1:0]    head_plus;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_found_ff;
   logic                   rsp_found_in;
   logic [DATA_BITS-1:0]   rsp_first_ff;
   logic [DATA_BITS-1:0]   rsp_first_in;
   logic                   rsp_free;
   logic                   finish;

   // count memory interface
   cnt_cmd_type            cnt_cmd;
   logic [SYMBOL_BITS-1:0] cnt_rd_addr;
   logic [CNT_BITS-1:0]    cnt_rd_data;
   logic [CNT_BITS-1:0]    cnt_new;
   logic                   cnt_ready;

   // arrival-order queue memory
   logic [SYMBOL_BITS-1:0] queue_mem [DEPTH];
   logic [SYMBOL_BITS-1:0] q_rd_data_ff;
   logic                   q_rd_en;
   logic                   q_wr_en;

   logic                   req_accept;
   logic [SYMBOL_BITS-1:0] req_sym;

   fust_count_mem #(
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .cnt_cmd (cnt_cmd),
      .rd_addr (cnt_rd_addr),
      .wr_addr (sym_ff),
      .rd_data (cnt_rd_data),
      .ready   (cnt_ready)
   );

   assign req_tready = (state_ff == S_IDLE) & cnt_ready;
   assign req_accept = req_tvalid & req_tready;
   // mask (or widen) the port symbol to the alphabet width
   assign req_sym    = SYMBOL_BITS'(req_tdata);
   assign head_plus  = head_ff + 1'b1;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   // saturating increment
   assign cnt_new    = (cnt_rd_data >= CNT_SAT) ? CNT_SAT : cnt_rd_data + CNT_ONE;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      sym_in          = sym_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      hsym_in         = hsym_ff;
      finish          = 1'b0;
      q_rd_en         = 1'b0;
      q_wr_en         = 1'b0;
      cnt_cmd.rd_en   = 1'b0;
      cnt_cmd.wr_en   = 1'b0;
      cnt_cmd.wr_data = cnt_new;
      cnt_rd_addr     = req_sym;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               sym_in        = req_sym;
               cnt_cmd.rd_en = 1'b1;
               state_in      = S_UPD;
            end
         end
         S_UPD: begin
            cnt_cmd.wr_en = 1'b1;
            if (cnt_rd_data == CNT_ZERO) begin
               // first occurrence: append to the queue
               q_wr_en = 1'b1;
               tail_in = tail_ff + 1'b1;
               if (head_ff == tail_ff) begin
                  hsym_in = sym_ff;
               end
               finish = 1'b1;
            end else if (head_ff != tail_ff && hsym_ff == sym_ff) begin
               // head symbol just repeated: pop it
               head_in = head_plus;
               if (head_plus == tail_ff) begin
                  finish = 1'b1;
               end else begin
                  q_rd_en  = 1'b1;
                  state_in = S_QRD;
               end
            end else begin
               finish = 1'b1;
            end
         end
         S_QRD: begin
            hsym_in       = q_rd_data_ff;
            cnt_rd_addr   = q_rd_data_ff;
            cnt_cmd.rd_en = 1'b1;
            state_in      = S_CCHK;
         end
         S_CCHK: begin
            if (cnt_rd_data >= CNT_SAT) begin
               // stale head: pop and look at the next one
               head_in = head_plus;
               if (head_plus == tail_ff) begin
                  finish = 1'b1;
               end else begin
                  q_rd_en  = 1'b1;
                  state_in = S_QRD;
               end
            end else begin
               finish = 1'b1;
            end
         end
         S_OUT: begin
            finish = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         state_in = rsp_free ? S_IDLE : S_OUT;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_first_in = rsp_first_ff;
      if (finish && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = (head_in != tail_in);
         rsp_first_in = (head_in != tail_in) ? DATA_BITS'(hsym_in) : NONE_MARK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      hsym_ff      <= hsym_in;
      rsp_found_ff <= rsp_found_in;
      rsp_first_ff <= rsp_first_in;
   end

   // queue memory: write at tail, registered read at the next head
   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         queue_mem[tail_ff[SYMBOL_BITS-1:0]] <= sym_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_rd_en) begin
         q_rd_data_ff <= queue_mem[head_plus[SYMBOL_BITS-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_first_ff;
   assign rsp_tuser  = rsp_found_ff;

   // queue occupancy never exceeds the alphabet size
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      PTR_BITS'(tail_ff - head_ff) <= PTR_BITS'(DEPTH))
      else $error("order queue overflow");

   // the count read back during update is never beyond saturation
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (cnt_rd_data <= CNT_SAT))
      else $error("occurrence count above saturation");

   // a push into an empty queue makes the pushed symbol the cached head
   a_head_cache: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && cnt_rd_data == CNT_ZERO && head_ff == tail_ff)
      |=> (hsym_ff == $past(sym_ff)))
      else $error("head cache not loaded on push into empty queue");

   // a result without a unique symbol always carries the none mark
   a_none_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_first_ff == NONE_MARK))
      else $error("empty result without none mark");

endmodule

FILE: bench/tb_first_unique_symbol_tracker.sv
`timescale 1ns / 1ps
// self-checking bench for first_unique_symbol_tracker: random and directed symbol
// streams with a built-in first-unique predictor; depends on fust_pkg and the RTL
module tb_first_unique_symbol_tracker;

   import fust_pkg::*;

   localparam int SYM_BITS   = SYMBOL_BITS_DEF;
   localparam int SYM_DEPTH  = 1 << SYM_BITS;
   localparam int IDLE_PCT   = 14;
   localparam int RAND_ITEMS = 700;
   localparam int QUIET_MAX  = 5000;   // covers the clear sweep and a full pop chain
   localparam int DRAIN_WAIT = 16;

   // one result item as the block reports it
   typedef struct packed {
      logic                 found;
      logic [DATA_BITS-1:0] first_once;
   } answer_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;   // [7:0] symbol
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;         // [7:0] first_once
   logic                 rsp_tuser;         // [0] found

   first_unique_symbol_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // symbols waiting to be offered, filled up front by the stimulus block
   logic [DATA_BITS-1:0] symbols_pending [$];
   // answers predicted for accepted symbols, oldest first
   answer_type           answers_due [$];

   // predictor state: saturating counts plus the arrival-order queue
   logic [CNT_BITS-1:0]  seen_count    [SYM_DEPTH];
   logic [SYM_BITS-1:0]  arrival_order [SYM_DEPTH];
   logic [SYM_BITS:0]    arrival_head;
   logic [SYM_BITS:0]    arrival_tail;

   int  symbols_taken = 0;
   int  answers_seen  = 0;
   int  unique_hits   = 0;
   int  mismatches    = 0;
   int  quiet_cycles  = 0;
   logic req_taken    = 1'b0;

   // no idling on either side while this window of items passes through
   wire steady_phase = (symbols_taken >= 300) && (symbols_taken < 450);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // fold one symbol into the predictor and return the answer the block owes
   function automatic answer_type advance_tracker(input logic [DATA_BITS-1:0] symbol_in);
      logic [SYM_BITS-1:0] sym;
      answer_type          ans;
      sym = symbol_in[SYM_BITS-1:0];   // symbols beyond the alphabet are masked
      if (seen_count[sym] != CNT_SAT)
         seen_count[sym] = seen_count[sym] + 1'b1;
      // first sighting joins the back of the arrival queue
      if (seen_count[sym] == CNT_ONE) begin
         arrival_order[arrival_tail[SYM_BITS-1:0]] = sym;
         arrival_tail = arrival_tail + 1'b1;
      end
      // drop heads that have since repeated
      while (arrival_head != arrival_tail &&
             seen_count[arrival_order[arrival_head[SYM_BITS-1:0]]] == CNT_SAT)
         arrival_head = arrival_head + 1'b1;
      ans.found      = (arrival_head != arrival_tail);
      ans.first_once = ans.found ? DATA_BITS'(arrival_order[arrival_head[SYM_BITS-1:0]])
                                 : NONE_MARK;
      return ans;
   endfunction

   // driver: inputs move on the falling edge; valid is held until the item is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (symbols_pending.size() > 0 &&
             (steady_phase || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= symbols_pending.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      // receiver stalls at random, except in the steady window
      rsp_tready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // monitor and predictor: everything sampled on the rising edge
   always @(posedge clock) begin
      answer_type want;
      req_taken <= req_tvalid && req_tready;
      if (reset) begin
         for (int i = 0; i < SYM_DEPTH; i++) begin
            seen_count[i]    = CNT_ZERO;
            arrival_order[i] = '0;
         end
         arrival_head = '0;
         arrival_tail = '0;
      end else begin
         // results are checked before this edge's symbol is predicted
         if (rsp_tvalid && rsp_tready) begin
            answers_seen++;
            if (rsp_tuser)
               unique_hits++;
            if (answers_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result item with nothing pending: found %0b data %0d",
                           $realtime, rsp_tuser, rsp_tdata);
            end else begin
               want = answers_due.pop_front();
               if (rsp_tuser !== want.found || rsp_tdata !== want.first_once) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result %0d: found %0b/%0b data %0d/%0d (want/got)",
                              $realtime, answers_seen, want.found, rsp_tuser,
                              want.first_once, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            answers_due = {answers_due, advance_tracker(req_tdata)};
            symbols_taken++;
         end
         // watchdog on cycles with no traffic at all
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
               $display("timeout after %0d idle cycles, %0d results still owed",
                        quiet_cycles, answers_due.size());
               $display("first_unique_symbol_tracker: mismatch");
               $finish;
            end
         end
      end
   end

   // stimulus: generator keeps its own view of which symbols are new, once-seen or done
   logic [CNT_BITS-1:0]  gen_count [SYM_DEPTH];
   logic [DATA_BITS-1:0] once_list [$];   // once-seen symbols in arrival order
   logic [DATA_BITS-1:0] unseen    [$];

   task automatic queue_symbol(input logic [DATA_BITS-1:0] sym);
      symbols_pending = {symbols_pending, sym};
      if (gen_count[sym] == CNT_ZERO) begin
         gen_count[sym] = CNT_ONE;
         once_list = {once_list, sym};
         foreach (unseen[i])
            if (unseen[i] == sym) begin
               unseen.delete(i);
               break;
            end
      end else if (gen_count[sym] == CNT_ONE) begin
         gen_count[sym] = CNT_SAT;
         foreach (once_list[i])
            if (once_list[i] == sym) begin
               once_list.delete(i);
               break;
            end
      end
   endtask

   initial begin
      int pick;
      for (int i = 0; i < SYM_DEPTH; i++) begin
         gen_count[i] = CNT_ZERO;
         unseen = {unseen, DATA_BITS'(i)};
      end

      // directed: extremes, repeats that pop the head, '#' as the unique symbol,
      // an empty answer and a count that stays saturated
      queue_symbol(8'h00);
      queue_symbol(8'hff);
      queue_symbol(8'haa);
      queue_symbol(8'h55);
      queue_symbol(NONE_MARK);
      queue_symbol(8'h00);
      queue_symbol(8'hff);
      queue_symbol(8'h55);     // stale entry behind the head
      queue_symbol(8'haa);     // head pop skips two entries, '#' is left unique
      queue_symbol(NONE_MARK); // nothing unique remains
      queue_symbol(8'h00);     // third sighting, count saturated
      queue_symbol(8'h01);
      queue_symbol(8'h80);
      queue_symbol(8'h01);
      queue_symbol(8'h80);
      queue_symbol(8'h7f);

      // random: fresh symbols, repeats of the oldest once-seen, other repeats, noise
      for (int n = 0; n < RAND_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40 && unseen.size() > 0)
            queue_symbol(unseen[$urandom_range(0, unseen.size() - 1)]);
         else if (pick < 55 && once_list.size() > 0)
            queue_symbol(once_list[0]);
         else if (pick < 80 && once_list.size() > 0)
            queue_symbol(once_list[$urandom_range(0, once_list.size() - 1)]);
         else
            queue_symbol(DATA_BITS'($urandom_range(0, SYM_DEPTH - 1)));
      end

      // drain: all symbols taken, all answers in, then a short settle for strays
      while (symbols_pending.size() > 0 || req_tvalid)
         @(posedge clock);
      while (answers_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d symbols sent, %0d distinct; %0d results checked, %0d with a unique symbol",
               symbols_taken, SYM_DEPTH - unseen.size(), answers_seen, unique_hits);
      if (mismatches > 0)
         $display("%0d mismatching results", mismatches);
      if (mismatches == 0)
         $display("first_unique_symbol_tracker: match");
      else
         $display("first_unique_symbol_tracker: mismatch");
      $finish;
   end

endmodule

FILE: first_unique_symbol_tracker.f
hdl/fust_pkg.sv
hdl/fust_count_mem.sv
hdl/first_unique_symbol_tracker.sv
bench/tb_first_unique_symbol_tracker.sv
